@@ rtl/uue_pkg.sv @@
package uue_pkg;

    localparam int UPC_W = 4;

    typedef enum logic [1:0]
    {
        OP_DATA  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_END   = 2'd2
    } opcode_t;

    // What the step puts into the output register
    typedef enum logic [2:0]
    {
        EM_NONE   = 3'd0,
        EM_LEN    = 3'd1,
        EM_GROUP  = 3'd2,
        EM_NL     = 3'd3,
        EM_NLBTNL = 3'd4,
        EM_END    = 3'd5
    } emit_t;

    typedef enum logic [1:0]
    {
        LT_NONE = 2'd0,
        LT_B0   = 2'd1,
        LT_B1   = 2'd2,
        LT_B2   = 2'd3
    } latch_t;

    typedef enum logic [2:0]
    {
        J_NEXT     = 3'd0,
        J_ALWAYS   = 3'd1,
        J_MORE     = 3'd2,  // jump while bytes remain in the line
        J_OPEN     = 3'd3,  // jump if begin was seen, else back to idle
        J_DISPATCH = 3'd4   // idle: decode the incoming item
    } jcond_t;

    typedef struct packed
    {
        emit_t              emit;
        latch_t             latch;
        logic               pos_clr;
        jcond_t             jcond;
        logic [UPC_W-1:0]   target;
        logic               clr_fill;
        logic               clr_open;
        logic               store_hold;
    } ucw_t;

    localparam logic [UPC_W-1:0] UPC_IDLE   = 4'd0;
    localparam logic [UPC_W-1:0] UPC_D_LEN  = 4'd1;
    localparam logic [UPC_W-1:0] UPC_D_B0   = 4'd2;
    localparam logic [UPC_W-1:0] UPC_D_B1   = 4'd3;
    localparam logic [UPC_W-1:0] UPC_D_B2   = 4'd4;
    localparam logic [UPC_W-1:0] UPC_D_GRP  = 4'd5;
    localparam logic [UPC_W-1:0] UPC_D_NL   = 4'd6;
    localparam logic [UPC_W-1:0] UPC_E_LEN  = 4'd7;
    localparam logic [UPC_W-1:0] UPC_E_B0   = 4'd8;
    localparam logic [UPC_W-1:0] UPC_E_B1   = 4'd9;
    localparam logic [UPC_W-1:0] UPC_E_B2   = 4'd10;
    localparam logic [UPC_W-1:0] UPC_E_GRP  = 4'd11;
    localparam logic [UPC_W-1:0] UPC_E_TERM = 4'd12;
    localparam logic [UPC_W-1:0] UPC_END    = 4'd13;

    localparam logic [6:0] CH_NL   = 7'h0A;
    localparam logic [6:0] CH_BT   = 7'h60;
    localparam logic [6:0] CH_E    = 7'h65;
    localparam logic [6:0] CH_N    = 7'h6E;
    localparam logic [6:0] CH_D    = 7'h64;
    localparam logic [6:0] CH_ZERO = 7'h00;

    localparam logic [2:0] CNT_1 = 3'd1;
    localparam logic [2:0] CNT_3 = 3'd3;
    localparam logic [2:0] CNT_4 = 3'd4;

    function automatic logic [6:0] six_to_char(input logic [5:0] v);
        return (v == 6'd0) ? CH_BT : ({1'b0, v} + 7'h20);
    endfunction

    // Microcode: one control word per step
    function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucw_t w;
        w.emit       = EM_NONE;
        w.latch      = LT_NONE;
        w.pos_clr    = 1'b0;
        w.jcond      = J_NEXT;
        w.target     = UPC_IDLE;
        w.clr_fill   = 1'b0;
        w.clr_open   = 1'b0;
        w.store_hold = 1'b0;
        case (addr)
            UPC_IDLE:
            begin
                w.jcond = J_DISPATCH;
            end
            UPC_D_LEN, UPC_E_LEN:
            begin
                w.emit    = EM_LEN;
                w.pos_clr = 1'b1;
            end
            UPC_D_B0, UPC_E_B0:
            begin
                w.latch = LT_B0;
            end
            UPC_D_B1, UPC_E_B1:
            begin
                w.latch = LT_B1;
            end
            UPC_D_B2, UPC_E_B2:
            begin
                w.latch = LT_B2;
            end
            UPC_D_GRP:
            begin
                w.emit   = EM_GROUP;
                w.jcond  = J_MORE;
                w.target = UPC_D_B0;
            end
            UPC_E_GRP:
            begin
                w.emit   = EM_GROUP;
                w.jcond  = J_MORE;
                w.target = UPC_E_B0;
            end
            UPC_D_NL:
            begin
                w.emit       = EM_NL;
                w.jcond      = J_ALWAYS;
                w.target     = UPC_IDLE;
                w.store_hold = 1'b1;
            end
            UPC_E_TERM:
            begin
                w.emit     = EM_NLBTNL;
                w.jcond    = J_OPEN;
                w.target   = UPC_END;
                w.clr_fill = 1'b1;
            end
            UPC_END:
            begin
                w.emit     = EM_END;
                w.jcond    = J_ALWAYS;
                w.target   = UPC_IDLE;
                w.clr_open = 1'b1;
            end
            default:
            begin
                w.jcond  = J_ALWAYS;
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/uuencode_line_encoder_core.sv @@
// uuencode line encoder.
// Input channel s_*: s_tuser carries the opcode (data, begin, end), s_tdata the byte.
// Output channel m_*: each item holds up to four ASCII characters and a count;
// m_tlast marks the final item caused by one input item.
// Data bytes into a non-full line are taken one per cycle and give no output.
// A byte that finds the line full starts a flush run by a small microcode
// sequencer: length item, then per group of three bytes three read steps of the
// line buffer (one byte each over its single read port) plus one emit step,
// then a newline item; the byte is stored in the newline step. s_tready
// returns when the run ends. An end item on a non-empty line runs a flush of
// the same form, ending in a newline, backtick, newline item, then the end text
// when begin was seen.
// s_tready is high only while the sequencer is idle.
// If the receiver stalls, the output register holds its item and the sequencer
// waits on the emitting step; an item appears in the cycle after its step.
// Reset empties the line, clears the begin flag and drops m_tvalid; the line
// buffer contents are not cleared.
module uuencode_line_encoder_core #(
    parameter int LINE_BYTES = 45
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // char_a[6:0], char_b[13:7], char_c[20:14], char_d[27:21], char_count[30:28], 0
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    import uue_pkg::*;

    localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int FW = $clog2(LINE_BYTES + 1);
    localparam int PW = $clog2(LINE_BYTES + 3);
    localparam logic [FW-1:0] FULL_CNT = FW'(LINE_BYTES);
    localparam logic [PW-1:0] LAST_POS = PW'(LINE_BYTES);

    logic [7:0] line_mem [0:LINE_BYTES-1];

    logic [UPC_W-1:0] upc_reg, upc_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic             open_reg, open_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [7:0]       hold_reg, hold_next;
    logic [7:0]       b0_reg, b0_next;
    logic [7:0]       b1_reg, b1_next;
    logic [7:0]       b2_reg, b2_next;
    logic [7:0]       rdata_reg;
    logic             ovalid_reg, ovalid_next;
    logic [31:0]      odata_reg, odata_next;
    logic             olast_reg, olast_next;

    ucw_t             cw;
    logic             in_fire;
    logic             advance;
    logic             more;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [7:0]       wdata;
    logic [AW-1:0]    raddr;
    logic [7:0]       lbyte;
    logic [6:0]       ca, cb, cc, cd;
    logic [2:0]       ccnt;
    logic             clast;

    assign cw       = ucode_rom(upc_reg);
    assign s_tready = (upc_reg == UPC_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign advance  = !((cw.emit != EM_NONE) && ovalid_reg && !m_tready);
    assign more     = (pos_reg < PW'(fill_reg));
    // bytes past the fill level read as zero padding
    assign lbyte    = more ? rdata_reg : 8'd0;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

    // read address follows the next position so rdata_reg matches pos_reg
    assign raddr = (pos_next < LAST_POS) ? pos_next[AW-1:0] : '0;

    always_comb
    begin
        ca    = CH_ZERO;
        cb    = CH_ZERO;
        cc    = CH_ZERO;
        cd    = CH_ZERO;
        ccnt  = CNT_1;
        clast = 1'b0;
        case (cw.emit)
            EM_LEN:
            begin
                ca = six_to_char(6'(fill_reg));
            end
            EM_GROUP:
            begin
                ca   = six_to_char(b0_reg[7:2]);
                cb   = six_to_char({b0_reg[1:0], b1_reg[7:4]});
                cc   = six_to_char({b1_reg[3:0], b2_reg[7:6]});
                cd   = six_to_char(b2_reg[5:0]);
                ccnt = CNT_4;
            end
            EM_NL:
            begin
                ca    = CH_NL;
                clast = 1'b1;
            end
            EM_NLBTNL:
            begin
                ca    = CH_NL;
                cb    = CH_BT;
                cc    = CH_NL;
                ccnt  = CNT_3;
                clast = !open_reg;
            end
            EM_END:
            begin
                ca    = CH_E;
                cb    = CH_N;
                cc    = CH_D;
                cd    = CH_NL;
                ccnt  = CNT_4;
                clast = 1'b1;
            end
            default:
            begin
                clast = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        upc_next    = upc_reg;
        fill_next   = fill_reg;
        open_next   = open_reg;
        pos_next    = pos_reg;
        hold_next   = hold_reg;
        b0_next     = b0_reg;
        b1_next     = b1_reg;
        b2_next     = b2_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        we          = 1'b0;
        waddr       = fill_reg[AW-1:0];
        wdata       = s_tdata;

        if (advance)
        begin
            if (cw.emit != EM_NONE)
            begin
                ovalid_next = 1'b1;
                odata_next  = {1'b0, ccnt, cd, cc, cb, ca};
                olast_next  = clast;
            end

            if (cw.pos_clr)
            begin
                pos_next = '0;
            end
            else if (cw.latch != LT_NONE)
            begin
                pos_next = pos_reg + 1'b1;
            end

            case (cw.latch)
                LT_B0:   b0_next = lbyte;
                LT_B1:   b1_next = lbyte;
                LT_B2:   b2_next = lbyte;
                default: b0_next = b0_reg;
            endcase

            if (cw.clr_fill)
            begin
                fill_next = '0;
            end
            if (cw.clr_open)
            begin
                open_next = 1'b0;
            end
            if (cw.store_hold)
            begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = hold_reg;
                fill_next = FW'(1);
            end

            case (cw.jcond)
                J_NEXT:   upc_next = upc_reg + 1'b1;
                J_ALWAYS: upc_next = cw.target;
                J_MORE:   upc_next = more ? cw.target : upc_reg + 1'b1;
                J_OPEN:   upc_next = open_reg ? cw.target : UPC_IDLE;
                J_DISPATCH:
                begin
                    if (in_fire)
                    begin
                        case (s_tuser)
                            OP_DATA:
                            begin
                                if (fill_reg >= FULL_CNT)
                                begin
                                    hold_next = s_tdata;
                                    upc_next  = UPC_D_LEN;
                                end
                                else
                                begin
                                    we        = 1'b1;
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                            OP_BEGIN:
                            begin
                                open_next = 1'b1;
                            end
                            OP_END:
                            begin
                                if (fill_reg != '0)
                                begin
                                    upc_next = UPC_E_LEN;
                                end
                                else if (open_reg)
                                begin
                                    upc_next = UPC_END;
                                end
                            end
                            default:
                            begin
                                upc_next = UPC_IDLE;
                            end
                        endcase
                    end
                end
                default:  upc_next = UPC_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg    <= UPC_IDLE;
            fill_reg   <= '0;
            open_reg   <= 1'b0;
            pos_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            upc_reg    <= upc_next;
            fill_reg   <= fill_next;
            open_reg   <= open_next;
            pos_reg    <= pos_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg  <= hold_next;
        b0_reg    <= b0_next;
        b1_reg    <= b1_next;
        b2_reg    <= b2_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            line_mem[waddr] <= wdata;
        end
        rdata_reg <= line_mem[raddr];
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import uue_pkg::*;

    localparam int LINE_BYTES   = 45;
    localparam int MAX_WORDS    = 18;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 100;
    localparam int ERR_PRINTS   = 40;

    // opcode the block must ignore
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct packed
    {
        logic [6:0] ch0;
        logic [6:0] ch1;
        logic [6:0] ch2;
        logic [6:0] ch3;
        logic [2:0] count;
        logic       last;
    } uu_word_t;

    // one line of the directed script; literal rows carry their own expectation
    typedef struct packed
    {
        logic [1:0] op;
        logic [7:0] data;
        logic       literal;
        logic       lit_one;
        uu_word_t   lit_word;
    } script_row_t;

    localparam uu_word_t NO_WORD  = '0;
    localparam uu_word_t END_WORD = '{ch0: CH_E, ch1: CH_N, ch2: CH_D, ch3: CH_NL,
                                      count: CNT_4, last: 1'b1};

    localparam int ROWS = 22;
    localparam script_row_t SCRIPT [ROWS] = '{
        '{OP_END,     8'h00, 1'b1, 1'b0, NO_WORD},   // empty line, no begin: silent
        '{OP_IGNORED, 8'hFF, 1'b1, 1'b0, NO_WORD},
        '{OP_BEGIN,   8'h00, 1'b1, 1'b0, NO_WORD},
        '{OP_BEGIN,   8'hFF, 1'b1, 1'b0, NO_WORD},   // begin while already open
        '{OP_END,     8'h00, 1'b1, 1'b1, END_WORD},
        '{OP_DATA,    8'h00, 1'b0, 1'b0, NO_WORD},
        '{OP_END,     8'hFF, 1'b0, 1'b0, NO_WORD},   // one byte, padded group
        '{OP_BEGIN,   8'h00, 1'b0, 1'b0, NO_WORD},
        '{OP_DATA,    8'hFF, 1'b0, 1'b0, NO_WORD},
        '{OP_DATA,    8'hFF, 1'b0, 1'b0, NO_WORD},
        '{OP_DATA,    8'hFF, 1'b0, 1'b0, NO_WORD},
        '{OP_DATA,    8'h00, 1'b0, 1'b0, NO_WORD},
        '{OP_IGNORED, 8'h55, 1'b1, 1'b0, NO_WORD},   // ignored mid-line
        '{OP_DATA,    8'hAA, 1'b0, 1'b0, NO_WORD},
        '{OP_DATA,    8'h55, 1'b0, 1'b0, NO_WORD},
        '{OP_END,     8'h00, 1'b0, 1'b0, NO_WORD},   // two whole groups, then closing text
        '{OP_DATA,    8'h01, 1'b0, 1'b0, NO_WORD},
        '{OP_DATA,    8'h80, 1'b0, 1'b0, NO_WORD},
        '{OP_DATA,    8'h7F, 1'b0, 1'b0, NO_WORD},
        '{OP_END,     8'h00, 1'b0, 1'b0, NO_WORD},   // whole group, no begin
        '{OP_IGNORED, 8'h00, 1'b1, 1'b0, NO_WORD},
        '{OP_DATA,    8'hFE, 1'b0, 1'b0, NO_WORD}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte[7:0]
    logic [1:0]  s_tuser;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // char_a, char_b, char_c, char_d, char_count, 0
    logic        m_tlast;

    // encoder state mirror
    logic [7:0] line_buf [LINE_BYTES];
    int         line_fill;
    logic       stream_begun;

    uu_word_t   step_words [MAX_WORDS];
    int         step_n;
    uu_word_t   pending_words [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_asks;
    int hold_seen;
    int hold_left;
    int items_driven;
    int words_checked;
    int full_flushes;
    int end_flushes;
    int mismatches;
    int quiet_cycles;

    uuencode_line_encoder_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [6:0] uu_char(input logic [5:0] v);
        return (v == 6'd0) ? CH_BT : ({1'b0, v} + 7'h20);
    endfunction

    function automatic void add_word(input logic [6:0] c0, input logic [6:0] c1,
                                     input logic [6:0] c2, input logic [6:0] c3,
                                     input logic [2:0] cnt);
        step_words[step_n] = '{ch0: c0, ch1: c1, ch2: c2, ch3: c3, count: cnt, last: 1'b0};
        step_n++;
    endfunction

    // length character, then four characters per group of three bytes
    function automatic void encode_line();
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] z;
        add_word(uu_char(6'(line_fill)), CH_ZERO, CH_ZERO, CH_ZERO, CNT_1);
        for (int i = 0; i < line_fill; i += 3)
        begin
            x = line_buf[i];
            y = (i + 1 < line_fill) ? line_buf[i + 1] : 8'h00;
            z = (i + 2 < line_fill) ? line_buf[i + 2] : 8'h00;
            add_word(uu_char(x[7:2]), uu_char({x[1:0], y[7:4]}),
                     uu_char({y[3:0], z[7:6]}), uu_char(z[5:0]), CNT_4);
        end
    endfunction

    // advance the mirror by one accepted item, leaving its words in step_words
    function automatic void encode_step(input logic [1:0] op, input logic [7:0] b);
        step_n = 0;
        case (op)
            OP_DATA:
            begin
                if (line_fill >= LINE_BYTES)
                begin
                    encode_line();
                    add_word(CH_NL, CH_ZERO, CH_ZERO, CH_ZERO, CNT_1);
                    line_fill = 0;
                    full_flushes++;
                end
                line_buf[line_fill] = b;
                line_fill++;
            end
            OP_BEGIN:
            begin
                stream_begun = 1'b1;
            end
            OP_END:
            begin
                if (line_fill != 0)
                begin
                    encode_line();
                    add_word(CH_NL, CH_BT, CH_NL, CH_ZERO, CNT_3);
                    line_fill = 0;
                    end_flushes++;
                end
                if (stream_begun)
                begin
                    add_word(CH_E, CH_N, CH_D, CH_NL, CNT_4);
                    stream_begun = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (step_n > 0)
            step_words[step_n - 1].last = 1'b1;
    endfunction

    function automatic void queue_step();
        for (int i = 0; i < step_n; i++)
            pending_words.push_back(step_words[i]);
    endfunction

    task automatic offer_item(input logic [1:0] op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= 2'($urandom_range(3));
            s_tdata  <= 8'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        if (op != OP_IGNORED)
            items_driven++;
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        offer_item(op, b);
        encode_step(op, b);
        queue_step();
    endtask

    // mostly begin / bytes / end runs with random content, some loose noise
    task automatic send_random_run();
        int n;
        int r;
        if ($urandom_range(99) < 80)
        begin
            if ($urandom_range(99) < 85)
                send_item(OP_BEGIN, 8'($urandom));
            r = $urandom_range(99);
            if (r < 50)
                n = $urandom_range(12);
            else if (r < 80)
                n = $urandom_range(48, 42);
            else
                n = $urandom_range(95, 85);
            repeat (n)
            begin
                if ($urandom_range(99) < 5)
                    send_item(OP_IGNORED, 8'($urandom));
                send_item(OP_DATA, 8'($urandom));
            end
            send_item(OP_END, 8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(4, 1))
                send_item(2'($urandom_range(3)), 8'($urandom));
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < ERR_PRINTS)
            $display("%0t: word %0d %s mismatch: got %02h want %02h",
                     $realtime, words_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_word();
        uu_word_t got;
        uu_word_t want;
        got.ch0   = m_tdata[6:0];
        got.ch1   = m_tdata[13:7];
        got.ch2   = m_tdata[20:14];
        got.ch3   = m_tdata[27:21];
        got.count = m_tdata[30:28];
        got.last  = m_tlast;
        if (pending_words.size() == 0)
        begin
            report_mismatch("unexpected", 8'(got.ch0), 8'h00);
        end
        else
        begin
            want = pending_words.pop_front();
            if (got.ch0 !== want.ch0)
                report_mismatch("char_a", 8'(got.ch0), 8'(want.ch0));
            if (got.ch1 !== want.ch1)
                report_mismatch("char_b", 8'(got.ch1), 8'(want.ch1));
            if (got.ch2 !== want.ch2)
                report_mismatch("char_c", 8'(got.ch2), 8'(want.ch2));
            if (got.ch3 !== want.ch3)
                report_mismatch("char_d", 8'(got.ch3), 8'(want.ch3));
            if (got.count !== want.count)
                report_mismatch("char_count", 8'(got.count), 8'(want.count));
            if (got.last !== want.last)
                report_mismatch("last", 8'(got.last), 8'(want.last));
        end
        words_checked++;
    endtask

    // receiver: checks words, drives m_tready, runs the long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_word();
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("uuencode_line_encoder_core verification failed");
            $finish;
        end
    end

    initial
    begin
        int start;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tuser       = OP_DATA;
        m_tready      = 1'b0;
        hold_asks     = 0;
        hold_seen     = 0;
        hold_left     = 0;
        items_driven  = 0;
        words_checked = 0;
        full_flushes  = 0;
        end_flushes   = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        line_fill     = 0;
        stream_begun  = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 74;
        for (int i = 0; i < LINE_BYTES; i++)
            line_buf[i] = 8'h00;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < ROWS; r++)
        begin
            offer_item(SCRIPT[r].op, SCRIPT[r].data);
            encode_step(SCRIPT[r].op, SCRIPT[r].data);
            if (SCRIPT[r].literal)
            begin
                if (SCRIPT[r].lit_one)
                    pending_words.push_back(SCRIPT[r].lit_word);
            end
            else
            begin
                queue_step();
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 37 : 0;
            start = items_driven;
            if (phase == 2)
            begin
                // receiver stalls long while a full line and more is offered
                hold_asks++;
                send_item(OP_BEGIN, 8'($urandom));
                repeat (60) send_item(OP_DATA, 8'($urandom));
                send_item(OP_END, 8'($urandom));
            end
            while (items_driven - start < PHASE_ITEMS)
                send_random_run();
        end
        s_tvalid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d items: %0d full-line flushes, %0d end flushes, %0d words checked",
                 items_driven, full_flushes, end_flushes, words_checked);
        $display("under both idling mixes, no idling, and one long receiver hold-off");
        if (mismatches == 0)
            $display("uuencode_line_encoder_core verification clean");
        else
            $display("uuencode_line_encoder_core verification failed");
        $finish;
    end

endmodule
